// File: sv/bba_pkg.sv
package bba_pkg;

  localparam int ADDR_W = 64;
  localparam int SIZE_W = 48;
  localparam int TYPE_W = 2;
  localparam int STAT_W = 2;

  localparam logic [31:0] HASH_MUL = 32'd2654435761;

  localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_SEED  = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_NONE  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic done;
    logic too_big;
  } ord_stat_t;

endpackage

// File: sv/bba_order.sv
module bba_order import bba_pkg::*; #(
  parameter int NUM_ORDERS = 19,
  parameter int MIN_SHIFT = 12,
  localparam int OW = $clog2(NUM_ORDERS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SIZE_W-1:0] size,
  output logic [OW-1:0]     order,
  output ord_stat_t         stat
);

  logic [SIZE_W-1:0] v;
  logic              busy;
  logic              done;

  // one bit of ceil(log2(size)) per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        order <= '0;
        v     <= (size == '0) ? '0 : ((size - 1'b1) >> MIN_SHIFT);
      end else if (busy) begin
        if (v == '0 || order == OW'(NUM_ORDERS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          v     <= v >> 1;
          order <= order + 1'b1;
        end
      end
    end
  end

  assign stat = '{done: done, too_big: (order >= OW'(NUM_ORDERS))};

endmodule

// File: sv/buddy_block_allocator_top.sv
// a request is sized to an order first; then an alloc scans the free lists upward from
// that order, unlinks a block and splits it; a free looks up its buddy by hash chain,
// unlinks and merges it, and adds the resulting block to its list
// throughput: one request at a time, the next is taken in the cycle after the result is
// issued; a result not yet taken holds the following one in its output register
// reset: every bucket of the table is cleared to empty before the first request is taken
module buddy_block_allocator_top import bba_pkg::*; #(
  parameter int NUM_ORDERS = 19,
  parameter int MIN_SHIFT = 12,
  parameter int POOL_NODES = 2048,
  parameter int HASH_BUCKETS = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TYPE_W-1:0] req_type,
  input  logic [SIZE_W-1:0] req_size,
  input  logic [ADDR_W-1:0] block_addr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic [ADDR_W-1:0] alloc_addr,
  output logic              node_lost
);

  localparam int NW = $clog2(POOL_NODES + 1);
  localparam int IW = $clog2(POOL_NODES);
  localparam int HW = $clog2(HASH_BUCKETS);
  localparam int OW = $clog2(NUM_ORDERS + 1);
  localparam int LW = $clog2(NUM_ORDERS);
  localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

  typedef enum logic [21:0] {
    S_CLR      = 22'h000001,
    S_IDLE     = 22'h000002,
    S_ORD      = 22'h000004,
    S_SCAN     = 22'h000008,
    S_UL_RD    = 22'h000010,
    S_UL_LAT   = 22'h000020,
    S_UL_BKT   = 22'h000040,
    S_UL_HEAD  = 22'h000080,
    S_UL_CMP   = 22'h000100,
    S_UL_HN    = 22'h000200,
    S_UL_GIVE  = 22'h000400,
    S_SPLIT    = 22'h000800,
    S_FREE_CHK = 22'h001000,
    S_FIND_B   = 22'h002000,
    S_FIND_H   = 22'h004000,
    S_FIND_C   = 22'h008000,
    S_FIND_M   = 22'h010000,
    S_TAKE     = 22'h020000,
    S_TAKE_W   = 22'h040000,
    S_PUSH_A   = 22'h080000,
    S_PUSH_B   = 22'h100000,
    S_OUT      = 22'h200000
  } state_t;

  function automatic logic [HW-1:0] hash_of(input logic [ADDR_W-1:0] a);
    logic [HW-1:0]   k;
    logic [2*HW-1:0] p;
    k = a[MIN_SHIFT +: HW];
    p = k * HASH_MUL[HW-1:0];
    return p[HW-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] bytes_of(input logic [OW-1:0] o);
    return ADDR_W'(1) << (32'(o) + MIN_SHIFT);
  endfunction

  state_t state;

  // node pool and bucket memories
  logic [ADDR_W-1:0] base_mem [POOL_NODES];
  logic [OW-1:0]     ord_mem  [POOL_NODES];
  logic [NW-1:0]     next_mem [POOL_NODES];
  logic [NW-1:0]     prev_mem [POOL_NODES];
  logic [NW-1:0]     hn_mem   [POOL_NODES];
  logic [NW-1:0]     bkt_mem  [HASH_BUCKETS];

  logic [IW-1:0]     node_ra;
  logic [ADDR_W-1:0] base_rd;
  logic [OW-1:0]     ord_rd;
  logic [NW-1:0]     next_rd, prev_rd, hn_rd, bkt_rd;
  logic              base_we, ord_we, next_we, prev_we, hn_we, bkt_we;
  logic [IW-1:0]     node_wa, next_wa, prev_wa, hn_wa;
  logic [NW-1:0]     next_wd, prev_wd, hn_wd, bkt_wd;
  logic [HW-1:0]     bkt_ra, bkt_wa;

  // request context
  logic [TYPE_W-1:0] kind;
  logic [OW-1:0]     req_order, o_cur, p_order;
  logic [ADDR_W-1:0] p_addr, base, mate, result;
  logic [STAT_W-1:0] status_r;
  logic              lost;
  logic [NW-1:0]     n, cur, chain_prev, spare_head, fresh;
  logic [HW-1:0]     hsh, clr_idx;
  logic [NW-1:0]     list_heads [NUM_ORDERS];

  logic              ord_start;
  logic [OW-1:0]     order_o;
  ord_stat_t         ostat;

  bba_order #(
    .NUM_ORDERS(NUM_ORDERS),
    .MIN_SHIFT(MIN_SHIFT)
  ) u_order (
    .clk(clk),
    .rst(rst),
    .start(ord_start),
    .size(req_size),
    .order(order_o),
    .stat(ostat)
  );

  assign in_ready  = (state == S_IDLE);
  assign ord_start = (state == S_IDLE) && in_valid;

  always_ff @(posedge clk) begin
    if (base_we) base_mem[node_wa] <= p_addr;
    if (ord_we)  ord_mem[node_wa]  <= p_order;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (hn_we)   hn_mem[hn_wa]     <= hn_wd;
    base_rd <= base_mem[node_ra];
    ord_rd  <= ord_mem[node_ra];
    next_rd <= next_mem[node_ra];
    prev_rd <= prev_mem[node_ra];
    hn_rd   <= hn_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
    bkt_rd <= bkt_mem[bkt_ra];
  end

  always_comb begin
    node_ra = n[IW-1:0];
    node_wa = n[IW-1:0];
    base_we = 1'b0;
    ord_we  = 1'b0;
    next_we = 1'b0;
    next_wa = n[IW-1:0];
    next_wd = spare_head;
    prev_we = 1'b0;
    prev_wa = n[IW-1:0];
    prev_wd = NIL;
    hn_we   = 1'b0;
    hn_wa   = n[IW-1:0];
    hn_wd   = bkt_rd;
    bkt_we  = 1'b0;
    bkt_ra  = hsh;
    bkt_wa  = hsh;
    bkt_wd  = n;
    case (state)
      S_CLR: begin
        bkt_we = 1'b1;
        bkt_wa = clr_idx;
        bkt_wd = NIL;
      end
      S_TAKE: node_ra = spare_head[IW-1:0];
      S_PUSH_A: begin
        base_we = 1'b1;
        ord_we  = 1'b1;
        next_we = 1'b1;
        next_wd = list_heads[p_order[LW-1:0]];
        prev_we = 1'b1;
        bkt_ra  = hash_of(p_addr);
      end
      S_PUSH_B: begin
        if (list_heads[p_order[LW-1:0]] != NIL) begin
          prev_we = 1'b1;
          prev_wa = list_heads[p_order[LW-1:0]][IW-1:0];
          prev_wd = n;
        end
        hn_we  = 1'b1;
        bkt_we = 1'b1;
      end
      S_UL_LAT: begin
        if (prev_rd != NIL) begin
          next_we = 1'b1;
          next_wa = prev_rd[IW-1:0];
          next_wd = next_rd;
        end
        if (next_rd != NIL) begin
          prev_we = 1'b1;
          prev_wa = next_rd[IW-1:0];
          prev_wd = prev_rd;
        end
      end
      S_UL_CMP: node_ra = cur[IW-1:0];
      S_UL_HN: begin
        // splice the node out of its hash chain
        if (cur == n) begin
          hn_wd  = hn_rd;
          bkt_wd = hn_rd;
          if (chain_prev != NIL) begin
            hn_we = 1'b1;
            hn_wa = chain_prev[IW-1:0];
          end else begin
            bkt_we = 1'b1;
          end
        end
      end
      S_UL_GIVE: next_we = 1'b1;
      S_FIND_B: bkt_ra = hash_of(mate);
      S_FIND_C: node_ra = cur[IW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_idx    <= '0;
      spare_head <= NIL;
      fresh      <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < NUM_ORDERS; i++) list_heads[i] <= NIL;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == HW'(HASH_BUCKETS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            kind     <= req_type;
            p_addr   <= block_addr;
            lost     <= 1'b0;
            status_r <= STAT_DONE;
            result   <= '0;
            state    <= S_ORD;
          end
        end
        S_ORD: begin
          if (ostat.done) begin
            req_order <= order_o;
            o_cur     <= order_o;
            p_order   <= order_o;
            if (kind == REQ_NONE) begin
              state <= S_OUT;
            end else if (ostat.too_big) begin
              status_r <= STAT_RANGE;
              state    <= S_OUT;
            end else if (kind == REQ_ALLOC) begin
              state <= S_SCAN;
            end else if (kind == REQ_FREE) begin
              state <= S_FREE_CHK;
            end else begin
              state <= S_TAKE;
            end
          end
        end
        S_SCAN: begin
          if (o_cur == OW'(NUM_ORDERS)) begin
            status_r <= STAT_EMPTY;
            state    <= S_OUT;
          end else if (list_heads[o_cur[LW-1:0]] != NIL) begin
            n     <= list_heads[o_cur[LW-1:0]];
            state <= S_UL_RD;
          end else begin
            o_cur <= o_cur + 1'b1;
          end
        end
        S_UL_RD: state <= S_UL_LAT;
        S_UL_LAT: begin
          if (prev_rd == NIL) list_heads[ord_rd[LW-1:0]] <= next_rd;
          base  <= base_rd;
          hsh   <= hash_of(base_rd);
          state <= S_UL_BKT;
        end
        S_UL_BKT: begin
          chain_prev <= NIL;
          state      <= S_UL_HEAD;
        end
        S_UL_HEAD: begin
          cur   <= bkt_rd;
          state <= S_UL_CMP;
        end
        S_UL_CMP: state <= (cur == NIL) ? S_UL_GIVE : S_UL_HN;
        S_UL_HN: begin
          if (cur == n) begin
            state <= S_UL_GIVE;
          end else begin
            chain_prev <= cur;
            cur        <= hn_rd;
            state      <= S_UL_CMP;
          end
        end
        S_UL_GIVE: begin
          spare_head <= n;
          if (kind == REQ_ALLOC) begin
            state <= S_SPLIT;
          end else begin
            if (mate < p_addr) p_addr <= mate;
            p_order <= p_order + 1'b1;
            state   <= S_FREE_CHK;
          end
        end
        S_SPLIT: begin
          if (o_cur > req_order) begin
            o_cur   <= o_cur - 1'b1;
            p_order <= o_cur - 1'b1;
            p_addr  <= base + bytes_of(o_cur - 1'b1);
            state   <= S_TAKE;
          end else begin
            result <= base;
            state  <= S_OUT;
          end
        end
        S_FREE_CHK: begin
          if (p_order < OW'(NUM_ORDERS - 1)) begin
            mate  <= p_addr ^ bytes_of(p_order);
            state <= S_FIND_B;
          end else begin
            state <= S_TAKE;
          end
        end
        S_FIND_B: state <= S_FIND_H;
        S_FIND_H: begin
          cur   <= bkt_rd;
          state <= S_FIND_C;
        end
        S_FIND_C: state <= (cur == NIL) ? S_TAKE : S_FIND_M;
        S_FIND_M: begin
          if (base_rd == mate && ord_rd == p_order) begin
            n     <= cur;
            state <= S_UL_RD;
          end else begin
            cur   <= hn_rd;
            state <= S_FIND_C;
          end
        end
        S_TAKE: begin
          // recycled nodes first, then never-used ones
          if (spare_head != NIL) begin
            n     <= spare_head;
            state <= S_TAKE_W;
          end else if (fresh != NIL) begin
            n     <= fresh;
            fresh <= fresh + 1'b1;
            state <= S_PUSH_A;
          end else begin
            lost  <= 1'b1;
            state <= (kind == REQ_ALLOC) ? S_SPLIT : S_OUT;
          end
        end
        S_TAKE_W: begin
          spare_head <= next_rd;
          state      <= S_PUSH_A;
        end
        S_PUSH_A: begin
          hsh   <= hash_of(p_addr);
          state <= S_PUSH_B;
        end
        S_PUSH_B: begin
          list_heads[p_order[LW-1:0]] <= n;
          state <= (kind == REQ_ALLOC) ? S_SPLIT : S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            status     <= status_r;
            alloc_addr <= result;
            node_lost  <= lost;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
